>>> rtl/mm_pkg.sv
// Package for the matrix multiply block: types and constants.
// No dependencies; used by every other file in rtl/.
`default_nettype none
package mm_pkg;
   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 16;
   localparam int DIM_W          = 4;
   localparam int IDX_W          = 3;
   localparam int VALUE_W        = 16;
   localparam int SUM_W          = 40;

   localparam logic [1:0] REQ_WRITE_A = 2'd0;
   localparam logic [1:0] REQ_WRITE_B = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/mm_cell.sv
// One cell of the multiply-accumulate chain: holds one row element of A and
// the partial sum it hands to its right neighbor. Depends on mm_pkg.
`default_nettype none
module mm_cell #(
   parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic                           step,
   input  wire logic signed [ELEM_WIDTH-1:0]   a_value,
   input  wire logic signed [ELEM_WIDTH-1:0]   b_value,
   input  wire logic signed [mm_pkg::SUM_W-1:0] sum_prev,
   output logic signed [mm_pkg::SUM_W-1:0]     sum_next
);
   logic signed [ELEM_WIDTH-1:0]    a_ff;
   logic signed [2*ELEM_WIDTH-1:0]  prod;
   logic signed [mm_pkg::SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= a_value;
      end
      // add this cell's term to the partial sum arriving from the left neighbor
      if (step) begin
         sum_ff <= sum_prev + mm_pkg::SUM_W'(prod);
      end
   end

   assign prod     = a_ff * b_value;
   assign sum_next = sum_ff;
endmodule
`default_nettype wire

>>> rtl/matrix_multiply.sv
// Top level of the matrix multiply block: element stores, sequencer, cell chain.
// Depends on mm_pkg and mm_cell.
//
//  channel | ports               | handshake
//  --------+---------------------+------------------------------------
//  request | req_payload         | start & !busy
//  result  | rsp_payload         | rsp_strobe, one cycle, no stall
//  config  | csr_write/index/data| csr_write, immediate
//
// A load transfer writes one element of A or B. A compute transfer loads row i
// of A into the cells, one store read a cycle, then walks B columns: one
// B element a cycle enters cell k together with the partial sum from cell k-1.
// Reset is synchronous: it clears control and sets each dimension to 8; stores stay undefined.
// Results cannot be stalled by the receiver.
`default_nettype none
module matrix_multiply #(
   parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire mm_pkg::req_type           req_payload,
   output logic                           rsp_strobe,
   output mm_pkg::rsp_type                rsp_payload,
   input  wire logic                      csr_write,
   input  wire logic [1:0]                csr_index,
   input  wire logic [mm_pkg::DIM_W-1:0]  csr_data
);
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = mm_pkg::SUM_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOADA = 2'd1;
   localparam logic [1:0] ST_COL   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

   logic [mm_pkg::DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [1:0]  state_ff, state_in;
   logic [IW:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW:0] r_dim, k_dim, c_dim;

   // operand registers: latched store reads; cell strobes decoded from the phase and index of the read
   logic [ELEM_WIDTH-1:0]        rd_a_ff, rd_b_ff;
   logic [MAX_DIM-1:0]           cell_load;
   logic [MAX_DIM-1:0]           cell_step;
   logic signed [SW-1:0]         chain [MAX_DIM+1];
   logic                         rsp_strobe_ff;
   mm_pkg::rsp_type              rsp_ff;

   function automatic logic [IW:0] clamp(input logic [mm_pkg::DIM_W-1:0] v);
      if (v == '0) return (IW+1)'(1);
      if (32'(v) > MAX_DIM) return (IW+1)'(MAX_DIM);
      return (IW+1)'(v);
   endfunction

   assign r_dim = clamp(rows_ff);
   assign k_dim = clamp(inner_ff);
   assign c_dim = clamp(cols_ff);

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mm_pkg::DIM_W'(8);
         inner_ff <= mm_pkg::DIM_W'(8);
         cols_ff  <= mm_pkg::DIM_W'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            mm_pkg::CSR_ROWS_A:    rows_ff  <= csr_data;
            mm_pkg::CSR_INNER_DIM: inner_ff <= csr_data;
            mm_pkg::CSR_COLS_B:    cols_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // element writes; indices at or beyond MAX_DIM drop
   logic wr_ok;
   logic [AW-1:0] wr_addr;
   assign wr_ok = (32'(req_payload.row) < MAX_DIM) && (32'(req_payload.col) < MAX_DIM);
   assign wr_addr = AW'(32'(req_payload.row) * MAX_DIM + 32'(req_payload.col));

   logic [AW-1:0] rd_addr_a, rd_addr_b;
   assign rd_addr_a = AW'(32'(i_ff[IW-1:0]) * MAX_DIM + 32'(k_ff[IW-1:0]));
   assign rd_addr_b = AW'(32'(k_ff[IW-1:0]) * MAX_DIM + 32'(j_ff[IW-1:0]));

   always_ff @(posedge clock) begin
      if (start && !busy && wr_ok && req_payload.req_type == mm_pkg::REQ_WRITE_A) begin
         mem_a[wr_addr] <= ELEM_WIDTH'(req_payload.value);
      end
      if (start && !busy && wr_ok && req_payload.req_type == mm_pkg::REQ_WRITE_B) begin
         mem_b[wr_addr] <= ELEM_WIDTH'(req_payload.value);
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   // sequencer: LOADA reads A[i][k] for each k; COL reads B[k][j]; EMIT starts the
   // result strobe, then moves to the next column, the next row or idle
   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_payload.req_type == mm_pkg::REQ_COMPUTE) begin
               state_in = ST_LOADA;
               i_in = '0;
               j_in = '0;
               k_in = '0;
            end
         end
         ST_LOADA: begin
            if (k_ff == k_dim - 1'b1) begin
               k_in = '0;
               state_in = ST_COL;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_COL: begin
            if (k_ff == k_dim - 1'b1) begin
               k_in = '0;
               state_in = ST_EMIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (j_ff != c_dim - 1'b1) begin
               j_in = j_ff + 1'b1;
               state_in = ST_COL;
            end else if (i_ff != r_dim - 1'b1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
               state_in = ST_LOADA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read data of the cycle before: which cell and which phase it belongs to
   logic [1:0]  ph_ff;
   logic [IW:0] pk_ff;
   logic        emit_go_ff;
   mm_pkg::rsp_type pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         ph_ff         <= ST_IDLE;
         emit_go_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         ph_ff         <= state_ff;
         emit_go_ff    <= (state_ff == ST_EMIT);
         rsp_strobe_ff <= emit_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      pk_ff <= k_ff;
      pend_ff.out_row <= mm_pkg::IDX_W'(i_ff);
      pend_ff.out_col <= mm_pkg::IDX_W'(j_ff);
      pend_ff.sum     <= '0;
      pend_ff.last    <= (i_ff == r_dim - 1'b1) && (j_ff == c_dim - 1'b1);
      rsp_ff.out_row  <= pend_ff.out_row;
      rsp_ff.out_col  <= pend_ff.out_col;
      rsp_ff.last     <= pend_ff.last;
      // take the finished sum from the last cell in use
      rsp_ff.sum      <= chain[k_dim];
   end

   // steer the latched store read to its cell: A loads, B steps the sum
   always_comb begin
      for (int n = 0; n < MAX_DIM; n++) begin
         cell_load[n] = (ph_ff == ST_LOADA) && (32'(pk_ff) == n);
         cell_step[n] = (ph_ff == ST_COL) && (32'(pk_ff) == n);
      end
   end

   assign chain[0] = '0;
   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      mm_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
         .clock    (clock),
         .load     (cell_load[g]),
         .step     (cell_step[g]),
         .a_value  (rd_a_ff),
         .b_value  (rd_b_ff),
         .sum_prev (chain[g]),
         .sum_next (chain[g+1])
      );
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire
